// ----- hw/rtl/lws_pkg.sv -----
// Shared types and constants of the worm and soil lattice site-update block.
// Holds cell codes, operation and axis codes, probability register layout,
// channel payload structs and the controller state type. No dependencies.
package lws_pkg;

    // Field widths fixed by the channel payloads.
    localparam int COORD_W   = 6;
    localparam int COORD_N   = 1 << COORD_W;
    localparam int CELL_W    = 3;
    localparam int OP_W      = 2;
    localparam int AXIS_W    = 2;
    localparam int PROB_BITS = 16;
    localparam int DRAW_W    = PROB_BITS;
    localparam int PROB_W    = PROB_BITS + 1;
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [PROB_W-1:0] t_prob;
    typedef logic [DRAW_W-1:0] t_draw;

    // Cell codes. Codes five to seven may be stored but carry no meaning.
    localparam t_cell CELL_EMPTY    = 3'd0;
    localparam t_cell CELL_NUTRIENT = 3'd1;
    localparam t_cell CELL_SOIL     = 3'd2;
    localparam t_cell CELL_GREEN    = 3'd3;
    localparam t_cell CELL_BLUE     = 3'd4;

    // Operation codes. The unused code behaves as a read.
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    // Neighbour axis codes. The unused code turns an update into a read.
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // Probability register indexes.
    localparam int REG_SOIL_FILL      = 0;
    localparam int REG_DEATH          = 1;
    localparam int REG_GREEN_BIRTH    = 2;
    localparam int REG_BLUE_BIRTH     = 3;
    localparam int REG_GREEN_NUTRIENT = 4;
    localparam int REG_BLUE_NUTRIENT  = 5;

    // Probabilities in unsigned 1.16 fixed point.
    localparam t_prob PROB_ONE   = t_prob'(64'd1 << PROB_BITS);
    localparam t_prob PROB_HALF  = t_prob'(64'd1 << (PROB_BITS - 1));
    localparam t_prob PROB_DEATH = t_prob'(((64'd1 << PROB_BITS) * 25) / 1000);
    localparam t_prob PROB_ZERO  = t_prob'(0);

    localparam t_prob PROB_RESET [NUM_REGS] = '{
        PROB_HALF, PROB_DEATH, PROB_HALF, PROB_ONE, PROB_HALF, PROB_ZERO
    };

    // Channel payloads.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] site_x;
        logic [COORD_W-1:0] site_y;
        logic [COORD_W-1:0] site_z;
        t_cell              cell_value;
        logic [AXIS_W-1:0]  axis;
        logic               step_sign;
        t_draw              draw_first;
        t_draw              draw_second;
    } t_item;

    typedef struct packed {
        t_cell site_before;
        t_cell site_after;
        t_cell neighbour_before;
        t_cell neighbour_after;
    } t_result;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        t_prob                value;
    } t_cfg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SITE,
        ST_NBR,
        ST_WNB,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/lws_if.sv -----
// Valid/ready channel interfaces of the lattice site-update block.
// Carries the item, result and configuration payloads; depends on lws_pkg.

interface lws_item_if;
    logic              valid;
    logic              ready;
    lws_pkg::t_item    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lws_result_if;
    logic              valid;
    logic              ready;
    lws_pkg::t_result  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lws_cfg_if;
    logic              valid;
    logic              ready;
    lws_pkg::t_cfg     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lattice_worm_site_update.sv -----
// Worm and soil lattice site-update engine: top level with the cell memory.
// Depends on lws_pkg and the channel interfaces in lws_if.sv.
//
// Usage. Items arrive on i_item (write cell, read cell, or update at a site).
// Each item gives exactly one result on o_res: the site before and after and,
// for an update, the neighbour before and after (zero otherwise). Coordinates
// are taken modulo SIDE and neighbours wrap round the lattice.
// Probabilities are written through i_cfg at any time the block is idle;
// i_cfg is always ready and writes to indexes beyond the list are ignored.
// Software must load every cell before reading or updating it: the cell
// memory is not cleared at reset.
// Timing. The single-port cell memory sets the rate. A read or write item
// reads the site cell, then writes it (write only) and passes the result on.
// An update reads the site and the neighbour and then writes both: its
// result is passed on with the neighbour write. The next item is taken once
// the engine is idle again. One item is in flight at a time; i_item.ready is
// high only when idle. Reset returns the probabilities to their defaults and
// empties the result register. While the result register is full and stalled,
// the finished result is kept in r_s0 to r_n1 and the engine waits in ST_DONE.
module lattice_worm_site_update #(
    parameter int SIDE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lws_item_if.sink      i_item,
    lws_result_if.source  o_res,
    lws_cfg_if.sink       i_cfg
);

    localparam int CW    = (SIDE > 2) ? $clog2(SIDE) : 1;
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] C_LAST = CW'(SIDE - 1);
    localparam logic [CW-1:0] C_ONE  = CW'(1);
    localparam logic [CW-1:0] C_ZERO = CW'(0);

    // Controller and memory port.
    lws_pkg::t_state  r_state, n_state;
    lws_pkg::t_cell   mem_cells [DEPTH];
    lws_pkg::t_cell   r_rdata;
    logic             mem_re, mem_we;
    logic [AW-1:0]    mem_addr;
    lws_pkg::t_cell   mem_wdata;

    // Held item.
    logic [lws_pkg::OP_W-1:0] r_op;
    lws_pkg::t_cell           r_value;
    logic                     r_axis_ok;
    lws_pkg::t_draw           r_d1, r_d2;
    logic [AW-1:0]            r_site_addr, r_nb_addr;

    // Cell values gathered during the operation.
    lws_pkg::t_cell r_s0, r_s1, r_n0, r_n1;
    lws_pkg::t_cell upd_s1, upd_n1;

    // Probability registers and result register.
    lws_pkg::t_prob   r_prob [lws_pkg::NUM_REGS];
    logic             r_out_valid;
    lws_pkg::t_result r_out;
    logic             res_load;
    lws_pkg::t_result res_data;

    logic in_acc, out_free, is_write, is_update;

    assign in_acc    = i_item.valid && i_item.ready;
    assign out_free  = !r_out_valid || o_res.ready;
    assign is_write  = (r_op == lws_pkg::OP_WRITE);
    assign is_update = (r_op == lws_pkg::OP_UPDATE) && r_axis_ok;

    assign i_item.ready = (r_state == lws_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    // Coordinate reduction modulo SIDE as a constant lookup.
    logic [CW-1:0] mod_lut [lws_pkg::COORD_N];
    for (genvar g = 0; g < lws_pkg::COORD_N; g++) begin : g_mod
        assign mod_lut[g] = CW'(g % SIDE);
    end

    logic [CW-1:0] cx, cy, cz, cur, nxt, nbx, nby, nbz;
    assign cx = mod_lut[i_item.data.site_x];
    assign cy = mod_lut[i_item.data.site_y];
    assign cz = mod_lut[i_item.data.site_z];

    // Neighbour coordinate along the chosen axis, wrapping at both ends.
    always_comb begin
        unique case (i_item.data.axis)
            lws_pkg::AXIS_X: cur = cx;
            lws_pkg::AXIS_Y: cur = cy;
            lws_pkg::AXIS_Z: cur = cz;
            default:         cur = cx;
        endcase
        if (i_item.data.step_sign) begin
            nxt = (cur == C_LAST) ? C_ZERO : cur + C_ONE;
        end else begin
            nxt = (cur == C_ZERO) ? C_LAST : cur - C_ONE;
        end
        nbx = (i_item.data.axis == lws_pkg::AXIS_X) ? nxt : cx;
        nby = (i_item.data.axis == lws_pkg::AXIS_Y) ? nxt : cy;
        nbz = (i_item.data.axis == lws_pkg::AXIS_Z) ? nxt : cz;
    end

    // Item capture on transfer.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_item.data.operation;
            r_value     <= i_item.data.cell_value;
            r_axis_ok   <= (i_item.data.axis != lws_pkg::AXIS_NONE);
            r_d1        <= i_item.data.draw_first;
            r_d2        <= i_item.data.draw_second;
            r_site_addr <= {cx, cy, cz};
            r_nb_addr   <= {nbx, nby, nbz};
        end
    end

    // Update rule: r_s0 is the old site, r_rdata the old neighbour.
    logic           blue, death_hit, fill_hit, birth_hit, nut_hit;
    lws_pkg::t_prob p_birth, p_nut;
    always_comb begin
        blue      = (r_s0 == lws_pkg::CELL_BLUE);
        p_birth   = blue ? r_prob[lws_pkg::REG_BLUE_BIRTH]
                         : r_prob[lws_pkg::REG_GREEN_BIRTH];
        p_nut     = blue ? r_prob[lws_pkg::REG_BLUE_NUTRIENT]
                         : r_prob[lws_pkg::REG_GREEN_NUTRIENT];
        fill_hit  = {1'b0, r_d1} < r_prob[lws_pkg::REG_SOIL_FILL];
        death_hit = {1'b0, r_d1} < r_prob[lws_pkg::REG_DEATH];
        birth_hit = {1'b0, r_d2} < p_birth;
        nut_hit   = {1'b0, r_d2} < p_nut;
        upd_s1    = r_s0;
        upd_n1    = r_rdata;
        priority if (r_s0 == lws_pkg::CELL_EMPTY || r_s0 == lws_pkg::CELL_NUTRIENT) begin
            if (r_rdata == lws_pkg::CELL_SOIL && fill_hit) begin
                upd_s1 = lws_pkg::CELL_SOIL;
            end
        end else if (r_s0 == lws_pkg::CELL_GREEN || r_s0 == lws_pkg::CELL_BLUE) begin
            upd_s1 = lws_pkg::CELL_EMPTY;
            if (!death_hit) begin
                // The worm moves in; what it leaves behind depends on its target.
                upd_n1 = r_s0;
                priority if (r_rdata == lws_pkg::CELL_NUTRIENT) begin
                    upd_s1 = birth_hit ? r_s0 : lws_pkg::CELL_EMPTY;
                end else if (r_rdata == lws_pkg::CELL_SOIL) begin
                    upd_s1 = nut_hit ? lws_pkg::CELL_NUTRIENT : lws_pkg::CELL_EMPTY;
                end else if (r_rdata == lws_pkg::CELL_GREEN
                             || r_rdata == lws_pkg::CELL_BLUE) begin
                    upd_s1 = r_rdata;
                end else begin
                    upd_s1 = lws_pkg::CELL_EMPTY;
                end
            end
        end else begin
            upd_s1 = r_s0;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, memory port control and result loading.
    always_comb begin
        n_state   = r_state;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_site_addr;
        mem_wdata = r_value;
        res_load  = 1'b0;
        res_data  = '{site_before: r_s0, site_after: r_s1,
                      neighbour_before: r_n0, neighbour_after: r_n1};
        unique case (r_state)
            lws_pkg::ST_IDLE: begin
                if (in_acc) begin
                    mem_re   = 1'b1;
                    mem_addr = {cx, cy, cz};
                    n_state  = lws_pkg::ST_SITE;
                end
            end
            lws_pkg::ST_SITE: begin
                if (is_write) begin
                    mem_we = 1'b1;
                end
                if (is_update) begin
                    mem_re   = 1'b1;
                    mem_addr = r_nb_addr;
                    n_state  = lws_pkg::ST_NBR;
                end else begin
                    res_data = '{site_before: r_rdata,
                                 site_after: is_write ? r_value : r_rdata,
                                 neighbour_before: lws_pkg::CELL_EMPTY,
                                 neighbour_after: lws_pkg::CELL_EMPTY};
                    res_load = out_free;
                    n_state  = out_free ? lws_pkg::ST_IDLE : lws_pkg::ST_DONE;
                end
            end
            lws_pkg::ST_NBR: begin
                mem_we    = 1'b1;
                mem_wdata = upd_s1;
                n_state   = lws_pkg::ST_WNB;
            end
            lws_pkg::ST_WNB: begin
                mem_we    = 1'b1;
                mem_addr  = r_nb_addr;
                mem_wdata = r_n1;
                res_load  = out_free;
                n_state   = out_free ? lws_pkg::ST_IDLE : lws_pkg::ST_DONE;
            end
            lws_pkg::ST_DONE: begin
                res_load = out_free;
                n_state  = out_free ? lws_pkg::ST_IDLE : lws_pkg::ST_DONE;
            end
        endcase
    end

    // Single-port cell memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_cells[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem_cells[mem_addr];
        end
    end

    // Cell values kept for the result.
    always_ff @(posedge i_clk) begin
        if (r_state == lws_pkg::ST_SITE) begin
            r_s0 <= r_rdata;
            r_s1 <= is_write ? r_value : r_rdata;
            r_n0 <= lws_pkg::CELL_EMPTY;
            r_n1 <= lws_pkg::CELL_EMPTY;
        end
        if (r_state == lws_pkg::ST_NBR) begin
            r_s1 <= upd_s1;
            r_n0 <= r_rdata;
            r_n1 <= upd_n1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res_data;
        end
    end

    // Probability registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lws_pkg::NUM_REGS; k++) begin
                r_prob[k] <= lws_pkg::PROB_RESET[k];
            end
        end else if (i_cfg.valid && i_cfg.ready
                     && i_cfg.data.index < lws_pkg::REG_IDX_W'(lws_pkg::NUM_REGS)) begin
            r_prob[i_cfg.data.index] <= i_cfg.data.value;
        end
    end

endmodule

// ----- hw/rtl/lws_checker.sv -----
// Port-level checks of the lattice site-update block, bound to its top level.
// Depends on lws_pkg and lattice_worm_site_update.
module lws_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  lws_pkg::t_result i_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // The result register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Only one item is in flight: no new transfer right after one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input ready directly after a transfer");

    // Every item needs a memory read first: no result in the cycle after transfer.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(i_out_valid))
        else $error("result appeared without a memory read");

endmodule

bind lattice_worm_site_update lws_checker u_lws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
